FILE: rtl/ascending_priority_queue_unit_macros.svh
// Assertion macros shared by the queue RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASCENDING_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define ASCENDING_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define APQ_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("queue assertion failed");

// Next-cycle implication.
`define APQ_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("queue assertion failed");

`endif

FILE: rtl/apq_pkg.sv
`timescale 1ns / 1ps

package apq_pkg;

	localparam int DEPTH = 8;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic               insert;
		logic               remove;
		logic signed [31:0] value;
	} apq_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic               valid;
		logic               keep;
		logic signed [31:0] data;
	} apq_link_t;

endpackage

FILE: rtl/apq_cell.sv
`timescale 1ns / 1ps

module apq_cell
	import apq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  apq_cmd_t  cmd,
	input  apq_link_t left_link,
	input  apq_link_t right_link,
	output apq_link_t own_link
);

	logic               valid_q;
	logic signed [31:0] data_q;

	// hold when our entry is no larger than the new value (stable on ties)
	assign own_link.valid = valid_q;
	assign own_link.data  = data_q;
	assign own_link.keep  = valid_q && (data_q <= cmd.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.remove) begin
			valid_q <= right_link.valid;
		end else if (cmd.insert && !own_link.keep) begin
			valid_q <= left_link.keep ? 1'b1 : left_link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.remove) begin
			data_q <= right_link.data;
		end else if (cmd.insert && !own_link.keep) begin
			data_q <= left_link.keep ? cmd.value : left_link.data;
		end
	end

endmodule

FILE: rtl/ascending_priority_queue_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                     tuser
// s_axis   in   value[31:0]               operation[0]
// m_axis   out  removed_value[31:0]       status[1:0]
//
// One word in, one word out. A word is taken in the cycle it arrives and its
// result sits in the output register from the next cycle; sustained rate is
// one word per cycle while m_axis_tready holds, as the cell chain updates on each accepted word.
// Reset (arst_n low) empties the chain and the output register.
// A stalled result holds the input side only until it is taken: the input is
// ready whenever the output register is empty or being drained.

module ascending_priority_queue_unit
	import apq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [0:0]  s_axis_tuser,  // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] removed_value
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

`include "ascending_priority_queue_unit_macros.svh"

	logic               out_valid_q;
	logic signed [31:0] out_data_q;
	logic [1:0]         out_status_q;

	logic       accept;
	logic       full;
	logic       empty;
	apq_cmd_t   cmd;
	apq_link_t  links [DEPTH];
	logic [DEPTH-1:0] valid_vec;

	// take a word whenever the output register is free or draining
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// the chain is kept sorted ascending, so the head holds the minimum and
	// the last cell tells whether the queue is full
	assign empty = !links[0].valid;
	assign full  = links[DEPTH-1].valid;

	assign cmd.insert = accept && (s_axis_tuser[0] == OP_INSERT) && !full;
	assign cmd.remove = accept && (s_axis_tuser[0] == OP_REMOVE) && !empty;
	assign cmd.value  = $signed(s_axis_tdata);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			apq_link_t left_l;
			apq_link_t right_l;

			// head cell sees a neighbor that always keeps: a new minimum lands here
			if (gi == 0) begin : g_head
				assign left_l = '{valid: 1'b1, keep: 1'b1, data: '0};
			end else begin : g_mid
				assign left_l = links[gi-1];
			end

			// tail cell pulls in an empty slot on remove
			if (gi == DEPTH - 1) begin : g_tail
				assign right_l = '{valid: 1'b0, keep: 1'b0, data: '0};
			end else begin : g_body
				assign right_l = links[gi+1];
			end

			apq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.left_link  (left_l),
				.right_link (right_l),
				.own_link   (links[gi])
			);

			assign valid_vec[gi] = links[gi].valid;
		end
	endgenerate

	// result register: advance on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= cmd.remove ? links[0].data : 32'sd0;
			if (s_axis_tuser[0] == OP_INSERT) begin
				out_status_q <= full ? ST_OVERFLOW : ST_DONE;
			end else begin
				out_status_q <= empty ? ST_EMPTY : ST_DONE;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	// chain stays packed at the head and sorted ascending
	generate
		for (gi = 1; gi < DEPTH; gi++) begin : g_chk
			`APQ_ASSERT_IMP(a_sorted, links[gi].valid, links[gi-1].valid && (links[gi-1].data <= links[gi].data))
		end
	endgenerate

	// remove from empty returns zero with empty status
	`APQ_ASSERT_NXT(a_empty_rm, accept && (s_axis_tuser[0] == OP_REMOVE) && empty, (out_status_q == ST_EMPTY) && (out_data_q == 32'sd0))

	// a dropped insert leaves the occupancy untouched
	`APQ_ASSERT_NXT(a_ovf_hold, accept && (s_axis_tuser[0] == OP_INSERT) && full, $stable(valid_vec) && (out_status_q == ST_OVERFLOW))

endmodule
